// File: rtl/nps_pkg.sv
package nps_pkg;

	localparam int MAX_COMPONENTS_DEF = 64;
	localparam int COORD_WIDTH_DEF    = 24;
	localparam int CORDIC_STEPS_DEF   = 16;

	localparam int CORDIC_W  = 42;
	localparam int ANGLE_W   = 26;
	localparam int STEP_W    = 5;
	localparam int ATAN_LEN  = 24;
	localparam logic [23:0] GAIN_Q24 = 24'd10188014;

	typedef enum logic [1:0] {
		KIND_SKIP  = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [5:0]  entry_index;
		logic [22:0] radius;
		logic [15:0] angle;
		logic [23:0] cursor_x;
		logic [23:0] cursor_y;
	} item_t;

	function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
		logic signed [ANGLE_W-1:0] a;
		unique case (i)
			5'd0:  a = 26'sd2097152;
			5'd1:  a = 26'sd1238021;
			5'd2:  a = 26'sd654136;
			5'd3:  a = 26'sd332050;
			5'd4:  a = 26'sd166669;
			5'd5:  a = 26'sd83416;
			5'd6:  a = 26'sd41718;
			5'd7:  a = 26'sd20860;
			5'd8:  a = 26'sd10430;
			5'd9:  a = 26'sd5215;
			5'd10: a = 26'sd2608;
			5'd11: a = 26'sd1304;
			5'd12: a = 26'sd652;
			5'd13: a = 26'sd326;
			5'd14: a = 26'sd163;
			5'd15: a = 26'sd81;
			5'd16: a = 26'sd41;
			5'd17: a = 26'sd20;
			5'd18: a = 26'sd10;
			5'd19: a = 26'sd5;
			5'd20: a = 26'sd3;
			5'd21: a = 26'sd1;
			5'd22: a = 26'sd1;
			default: a = 26'sd0;
		endcase
		return a;
	endfunction

endpackage

// File: rtl/nps_ram.sv
module nps_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/nps_front.sv
module nps_front #(
	parameter int MAX_COMPONENTS = nps_pkg::MAX_COMPONENTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           mode,
	input  logic [5:0]     entry_index,
	input  logic [22:0]    radius,
	input  logic [15:0]    angle,
	input  logic [23:0]    cursor_x,
	input  logic [23:0]    cursor_y,
	output logic           q_valid,
	output nps_pkg::item_t q_item,
	input  logic           q_pop
);

	nps_pkg::item_t entry_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     count_q;
	nps_pkg::item_t item;
	logic           push;
	logic           pop;

	always_comb begin
		item.entry_index = entry_index;
		item.radius      = radius;
		item.angle       = angle;
		item.cursor_x    = cursor_x;
		item.cursor_y    = cursor_y;
		if (mode) begin
			item.kind = nps_pkg::KIND_QUERY;
		end else if (32'(entry_index) < MAX_COMPONENTS) begin
			item.kind = nps_pkg::KIND_LOAD;
		end else begin
			item.kind = nps_pkg::KIND_SKIP;
		end
	end

	assign in_ready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = entry_q[rptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/nps_back.sv
module nps_back #(
	parameter int MAX_COMPONENTS = nps_pkg::MAX_COMPONENTS_DEF,
	parameter int COORD_WIDTH    = nps_pkg::COORD_WIDTH_DEF,
	parameter int CORDIC_STEPS   = nps_pkg::CORDIC_STEPS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [6:0]     count_cfg,
	input  logic           q_valid,
	input  nps_pkg::item_t q_item,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [5:0]     nearest_index,
	output logic           none_found
);

	localparam int AW    = $clog2(MAX_COMPONENTS);
	localparam int NW    = $clog2(MAX_COMPONENTS + 1);
	localparam int W     = COORD_WIDTH;
	localparam int CW    = nps_pkg::CORDIC_W;
	localparam int ZW    = nps_pkg::ANGLE_W;
	localparam int SW    = nps_pkg::STEP_W;
	localparam int STEPS = (CORDIC_STEPS < nps_pkg::ATAN_LEN) ? CORDIC_STEPS
		: nps_pkg::ATAN_LEN;
	localparam int DW    = W + 1;
	localparam int QW    = 2 * DW;
	localparam int SUMW  = QW + 1;
	localparam logic signed [CW-1:0] SAT_HI = (CW'(1) << (W - 1)) - CW'(1);
	localparam logic signed [CW-1:0] SAT_LO = -SAT_HI - CW'(1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LMUL = 6'b000010,
		ST_LROT = 6'b000100,
		ST_LWR  = 6'b001000,
		ST_SCAN = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t                   state_q;
	logic [5:0]               slot_q;
	logic [22:0]              radius_q;
	logic [15:0]              angle_q;
	logic signed [CW-1:0]     x_q;
	logic signed [CW-1:0]     y_q;
	logic signed [ZW-1:0]     z_q;
	logic [SW-1:0]            step_q;
	logic signed [W-1:0]      cx_q;
	logic signed [W-1:0]      cy_q;
	logic [NW-1:0]            n_q;
	logic [NW-1:0]            k_q;
	logic                     v_s1;
	logic [AW-1:0]            idx_s1;
	logic                     v_s2;
	logic [AW-1:0]            idx_s2;
	logic [DW-1:0]            ax_s2;
	logic [DW-1:0]            ay_s2;
	logic                     v_s3;
	logic [AW-1:0]            idx_s3;
	logic [QW-1:0]            sqx_s3;
	logic [QW-1:0]            sqy_s3;
	logic [SUMW-1:0]          best_q;
	logic [AW-1:0]            best_idx_q;
	logic                     none_q;
	logic                     out_valid_q;
	logic [5:0]               nearest_q;
	logic                     none_out_q;

	logic                     we;
	logic [AW-1:0]            raddr;
	logic [2*W-1:0]           wdata;
	logic [2*W-1:0]           rdata;
	logic signed [W-1:0]      rx;
	logic signed [W-1:0]      ry;
	logic signed [DW-1:0]     dx;
	logic signed [DW-1:0]     dy;
	logic [SUMW-1:0]          dist_sum;
	logic signed [CW-1:0]     xs;
	logic signed [CW-1:0]     ys;
	logic signed [ZW-1:0]     atan_v;
	logic signed [CW-1:0]     cos_v;
	logic signed [CW-1:0]     sin_v;
	logic signed [W-1:0]      sat_x;
	logic signed [W-1:0]      sat_y;
	logic signed [31:0]       cx_ext;
	logic signed [31:0]       cy_ext;
	logic [NW-1:0]            n_next;
	logic                     issue;
	logic                     out_free;

	function automatic logic signed [W-1:0] round_sat(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] r;
		logic signed [W-1:0]  o;
		r = (v + CW'(32768)) >>> 16;
		if (r > SAT_HI) begin
			o = SAT_HI[W-1:0];
		end else if (r < SAT_LO) begin
			o = SAT_LO[W-1:0];
		end else begin
			o = r[W-1:0];
		end
		return o;
	endfunction

	assign xs     = x_q >>> step_q;
	assign ys     = y_q >>> step_q;
	assign atan_v = nps_pkg::atan_entry(step_q);

	always_comb begin
		unique case (angle_q[15:14])
			2'd0:    begin cos_v = x_q;  sin_v = y_q;  end
			2'd1:    begin cos_v = -y_q; sin_v = x_q;  end
			2'd2:    begin cos_v = -x_q; sin_v = -y_q; end
			default: begin cos_v = y_q;  sin_v = -x_q; end
		endcase
	end

	assign sat_x  = round_sat(sin_v);
	assign sat_y  = round_sat(cos_v);
	assign we     = (state_q == ST_LWR);
	assign wdata  = {sat_x, sat_y};
	assign raddr  = k_q[AW-1:0];
	assign rx     = rdata[2*W-1:W];
	assign ry     = rdata[W-1:0];
	assign dx     = DW'(cx_q) - DW'(rx);
	assign dy     = DW'(cy_q) - DW'(ry);
	assign dist_sum = SUMW'(sqx_s3) + SUMW'(sqy_s3);
	assign issue  = (state_q == ST_SCAN) && (k_q < n_q);
	assign cx_ext = 32'(signed'(q_item.cursor_x));
	assign cy_ext = 32'(signed'(q_item.cursor_y));
	assign n_next = (32'(count_cfg) > MAX_COMPONENTS) ? NW'(MAX_COMPONENTS)
		: NW'(count_cfg);
	assign out_free = !out_valid_q || out_ready;
	assign q_pop  = (state_q == ST_IDLE) && q_valid;

	nps_ram #(
		.WIDTH(2 * W),
		.DEPTH(MAX_COMPONENTS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(slot_q[AW-1:0]),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		idx_s1 <= raddr;
		idx_s2 <= idx_s1;
		ax_s2  <= dx[DW-1] ? DW'(-dx) : DW'(dx);
		ay_s2  <= dy[DW-1] ? DW'(-dy) : DW'(dy);
		idx_s3 <= idx_s2;
		sqx_s3 <= QW'(ax_s2) * QW'(ax_s2);
		sqy_s3 <= QW'(ay_s2) * QW'(ay_s2);
		if (v_s3 && (idx_s3 == '0 || dist_sum < best_q)) begin
			best_q     <= dist_sum;
			best_idx_q <= idx_s3;
		end
		if (state_q == ST_FIN && out_free) begin
			nearest_q  <= none_q ? 6'd0 : 6'(best_idx_q);
			none_out_q <= none_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				slot_q   <= q_item.entry_index;
				radius_q <= q_item.radius;
				angle_q  <= q_item.angle;
				cx_q     <= cx_ext[W-1:0];
				cy_q     <= cy_ext[W-1:0];
				n_q      <= n_next;
				none_q   <= (n_next == '0);
			end
			ST_LMUL: begin
				x_q <= CW'((47'(radius_q) * 47'(nps_pkg::GAIN_Q24)) >> 8);
				y_q <= '0;
				z_q <= ZW'({angle_q[13:0], 8'd0});
			end
			ST_LROT: begin
				if (!z_q[ZW-1]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_v;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_v;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			k_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (out_valid_q && out_ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					k_q    <= '0;
					if (q_valid) begin
						unique case (q_item.kind)
							nps_pkg::KIND_LOAD:  state_q <= ST_LMUL;
							nps_pkg::KIND_QUERY: state_q <= (n_next == '0) ? ST_FIN : ST_SCAN;
							default:             state_q <= ST_IDLE;
						endcase
					end
				end
				ST_LMUL: state_q <= ST_LROT;
				ST_LROT: begin
					if (step_q == SW'(STEPS - 1)) begin
						state_q <= ST_LWR;
					end else begin
						step_q <= step_q + SW'(1);
					end
				end
				ST_LWR: state_q <= ST_IDLE;
				ST_SCAN: begin
					if (issue) begin
						k_q <= k_q + NW'(1);
					end else if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign nearest_index = nearest_q;
	assign none_found    = none_out_q;

endmodule

// File: rtl/nearest_polar_component_select_core.sv
// Nearest polar component select.
// Input channel (in_valid/in_ready): one word per item. mode 0 loads slot
// entry_index with the centre given by radius and angle; mode 1 queries the
// slot nearest to (cursor_x, cursor_y) among the first components_in_use.
// Output channel (out_valid/out_ready): one word per query, none per load.
// Config channel (cfg_valid/cfg_ready): writes components_in_use; always ready.
// A two-word queue sits in front of the execution unit, so input words are
// taken while the unit works or while a result waits at the output.
// Load: the execution unit does one gain multiply, one rotation per cycle
// and one table write, in that order.
// Query: the table is read one centre per cycle through a four-stage
// distance pipeline. With components_in_use at zero the query answers
// without a scan, with none_found set.
// Reset clears the queue, the count register and the output valid; table
// contents are undefined until loaded. A stalled receiver holds the result;
// the unit then waits in its final step and the queue fills behind it.
module nearest_polar_component_select_core #(
	parameter int MAX_COMPONENTS = nps_pkg::MAX_COMPONENTS_DEF,
	parameter int COORD_WIDTH    = nps_pkg::COORD_WIDTH_DEF,
	parameter int CORDIC_STEPS   = nps_pkg::CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  components_in_use,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [5:0]  entry_index,
	input  logic [22:0] radius,
	input  logic [15:0] angle,
	input  logic [23:0] cursor_x,
	input  logic [23:0] cursor_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  nearest_index,
	output logic        none_found
);

	logic [6:0]     count_q;
	logic           q_valid;
	logic           q_pop;
	nps_pkg::item_t q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 7'd0;
		end else if (cfg_valid) begin
			count_q <= components_in_use;
		end
	end

	nps_front #(
		.MAX_COMPONENTS(MAX_COMPONENTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.entry_index(entry_index),
		.radius     (radius),
		.angle      (angle),
		.cursor_x   (cursor_x),
		.cursor_y   (cursor_y),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	nps_back #(
		.MAX_COMPONENTS(MAX_COMPONENTS),
		.COORD_WIDTH   (COORD_WIDTH),
		.CORDIC_STEPS  (CORDIC_STEPS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.count_cfg    (count_q),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.nearest_index(nearest_index),
		.none_found   (none_found)
	);

endmodule
